// ===== hw/rtl/ffea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffea_pkg: shared types for the first-fit extent allocator
// Request and response payloads, operation codes and response status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffea_pkg;

  // Width of the address and count fields at the block ports.
  localparam int FIELD_BITS = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_MAP_FULL = 2'd2
  } status_e;

  typedef struct packed {
    op_e                   operation;
    logic [FIELD_BITS-1:0] unit_count;
    logic [FIELD_BITS-1:0] base_address;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] granted_base;
    status_e               status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffea_ram.sv =====
// ----------------------------------------------------------------------------
// ffea_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ffea_engine.sv =====
// ----------------------------------------------------------------------------
// ffea_engine: request sequencer of the first-fit extent allocator
// Scans the extent table in RAM, updates or merges entries and shifts the
// table up or down, then presents one response per request.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_engine #(
  parameter int MAP_ENTRIES = 64,
  parameter int ADDR_BITS   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  ffea_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output ffea_pkg::rsp_t                 rsp_o,
  output logic                           mem_we_o,
  output logic [$clog2(MAP_ENTRIES)-1:0] mem_waddr_o,
  output logic [2*ADDR_BITS-1:0]         mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(MAP_ENTRIES)-1:0] mem_raddr_o,
  input  logic [2*ADDR_BITS-1:0]         mem_rdata_i
);

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam int FB = ffea_pkg::FIELD_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE,
    S_MERGE2,
    S_ALLOC_UPD,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INSERT,
    S_RESP
  } state_e;

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[AW] ? {AW{1'b1}} : s[AW-1:0];
  endfunction

  state_e           state_q;
  ffea_pkg::op_e    op_q;
  logic [AW-1:0]    size_q;
  logic [AW-1:0]    a_q;
  logic [AW:0]      a_end_q;
  logic [CW-1:0]    n_q;
  logic [CW-1:0]    ptr_q;
  logic [CW-1:0]    pos_q;
  logic             rd_pend_q;
  logic [IW-1:0]    rd_idx_q;
  logic             prev_v_q;
  logic [AW-1:0]    prev_base_q;
  logic [AW-1:0]    prev_len_q;
  logic [AW:0]      prev_end_q;
  logic             cur_v_q;
  logic [AW-1:0]    cur_base_q;
  logic [AW-1:0]    cur_len_q;
  logic             mprev_q;
  logic             mnext_q;
  logic [AW-1:0]    acc_q;
  ffea_pkg::rsp_t   rsp_q;

  logic [AW-1:0] rd_base;
  logic [AW-1:0] rd_len;
  logic          scan_hit;
  logic          scan_stop;
  logic [AW-1:0] sum_prev;
  logic [AW-1:0] sum_cur;
  logic [AW-1:0] sum_join;
  logic [AW-1:0] req_size;
  logic [AW-1:0] req_addr;

  assign rd_base  = mem_rdata_i[2*AW-1:AW];
  assign rd_len   = mem_rdata_i[AW-1:0];
  assign sum_prev = sat_add(prev_len_q, size_q);
  assign sum_cur  = sat_add(cur_len_q, size_q);
  assign sum_join = sat_add(acc_q, cur_len_q);
  assign req_size = AW'(req_i.unit_count);
  assign req_addr = AW'(req_i.base_address);

  // An allocate stops at the first extent that is long enough; a free stops
  // at the first extent that starts above the freed address.
  assign scan_hit  = (op_q == ffea_pkg::OP_ALLOC) ? (rd_len >= size_q) : (rd_base > a_q);
  assign scan_stop = (state_q == S_SCAN) && rd_pend_q && scan_hit;

  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[IW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[IW-1:0];
    mem_wdata_o = '0;
    unique case (state_q)
      S_SCAN: begin
        mem_re_o = (ptr_q < n_q) && !scan_stop;
      end
      S_ALLOC_UPD: begin
        mem_we_o    = (cur_len_q != size_q);
        mem_wdata_o = {cur_base_q + size_q, cur_len_q - size_q};
      end
      S_MERGE: begin
        if (mprev_q && !mnext_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = IW'(pos_q - CW'(1));
          mem_wdata_o = {prev_base_q, sum_prev};
        end else if (!mprev_q && mnext_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {a_q, sum_cur};
        end
      end
      S_MERGE2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = IW'(pos_q - CW'(1));
        mem_wdata_o = {prev_base_q, sum_join};
      end
      S_SHIFT_DN: begin
        mem_re_o    = (ptr_q < n_q);
        mem_we_o    = rd_pend_q;
        mem_waddr_o = rd_idx_q - IW'(1);
        mem_wdata_o = mem_rdata_i;
      end
      S_SHIFT_UP: begin
        mem_re_o    = (ptr_q > pos_q);
        mem_raddr_o = IW'(ptr_q - CW'(1));
        mem_we_o    = rd_pend_q;
        mem_waddr_o = rd_idx_q + IW'(1);
        mem_wdata_o = mem_rdata_i;
      end
      S_INSERT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {a_q, size_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= ffea_pkg::OP_ALLOC;
      size_q      <= '0;
      a_q         <= '0;
      a_end_q     <= '0;
      n_q         <= '0;
      ptr_q       <= '0;
      pos_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      prev_v_q    <= 1'b0;
      prev_base_q <= '0;
      prev_len_q  <= '0;
      prev_end_q  <= '0;
      cur_v_q     <= 1'b0;
      cur_base_q  <= '0;
      cur_len_q   <= '0;
      mprev_q     <= 1'b0;
      mnext_q     <= 1'b0;
      acc_q       <= '0;
      rsp_q       <= '0;
    end else begin
      rd_pend_q <= mem_re_o;
      rd_idx_q  <= mem_raddr_o;
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q     <= req_i.operation;
            size_q   <= req_size;
            a_q      <= req_addr;
            a_end_q  <= {1'b0, req_addr} + {1'b0, req_size};
            ptr_q    <= '0;
            prev_v_q <= 1'b0;
            cur_v_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_re_o) begin
            ptr_q <= ptr_q + CW'(1);
          end
          if (rd_pend_q) begin
            if (scan_hit) begin
              cur_v_q    <= 1'b1;
              cur_base_q <= rd_base;
              cur_len_q  <= rd_len;
              pos_q      <= CW'(rd_idx_q);
              state_q    <= (op_q == ffea_pkg::OP_ALLOC) ? S_ALLOC_UPD : S_DECIDE;
            end else if (op_q == ffea_pkg::OP_FREE) begin
              prev_v_q    <= 1'b1;
              prev_base_q <= rd_base;
              prev_len_q  <= rd_len;
              prev_end_q  <= {1'b0, rd_base} + {1'b0, rd_len};
            end
          end else if (ptr_q == n_q) begin
            // Whole table seen without a stop.
            if (op_q == ffea_pkg::OP_ALLOC) begin
              rsp_q.granted_base <= '0;
              rsp_q.status       <= ffea_pkg::STATUS_NO_SPACE;
              state_q            <= S_RESP;
            end else begin
              pos_q   <= n_q;
              state_q <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          mprev_q <= prev_v_q && (prev_end_q == {1'b0, a_q});
          mnext_q <= cur_v_q && (a_end_q == {1'b0, cur_base_q});
          state_q <= S_MERGE;
        end
        S_MERGE: begin
          rsp_q.granted_base <= '0;
          rsp_q.status       <= ffea_pkg::STATUS_OK;
          priority if (mprev_q && mnext_q) begin
            acc_q   <= sum_prev;
            state_q <= S_MERGE2;
          end else if (mprev_q || mnext_q) begin
            state_q <= S_RESP;
          end else if (size_q == '0) begin
            state_q <= S_RESP;
          end else if (n_q == CW'(MAP_ENTRIES)) begin
            rsp_q.status <= ffea_pkg::STATUS_MAP_FULL;
            state_q      <= S_RESP;
          end else begin
            ptr_q   <= n_q;
            state_q <= S_SHIFT_UP;
          end
        end
        S_MERGE2: begin
          ptr_q   <= pos_q + CW'(1);
          state_q <= S_SHIFT_DN;
        end
        S_ALLOC_UPD: begin
          rsp_q.granted_base <= FB'(cur_base_q);
          rsp_q.status       <= ffea_pkg::STATUS_OK;
          if (cur_len_q == size_q) begin
            ptr_q   <= pos_q + CW'(1);
            state_q <= S_SHIFT_DN;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_SHIFT_DN: begin
          if (mem_re_o) begin
            ptr_q <= ptr_q + CW'(1);
          end else if (!rd_pend_q) begin
            n_q     <= n_q - CW'(1);
            state_q <= S_RESP;
          end
        end
        S_SHIFT_UP: begin
          if (mem_re_o) begin
            ptr_q <= ptr_q - CW'(1);
          end else if (!rd_pend_q) begin
            state_q <= S_INSERT;
          end
        end
        S_INSERT: begin
          n_q     <= n_q + CW'(1);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = rsp_q;

  // The sequencing never reads and writes the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("ffea_engine: read and write of the same entry in one cycle");

  // Writes stay inside the used part of the table, or at its first free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CW'(mem_waddr_o) <= n_q))
    else $error("ffea_engine: write beyond the used part of the table");

  // The entry count moves by at most one per request step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q == $past(n_q)) || (n_q == $past(n_q) + CW'(1)) || (n_q == $past(n_q) - CW'(1)))
    else $error("ffea_engine: entry count jumped");

  // A dropped free is only reported while the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ffea_pkg::STATUS_MAP_FULL)) |-> (n_q == CW'(MAP_ENTRIES)))
    else $error("ffea_engine: map_full reported with free slots left");

  // The count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |-> (n_q < CW'(MAP_ENTRIES)))
    else $error("ffea_engine: insert into a full table");

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_extent_allocator: first-fit free-extent map
// Keeps an address-sorted table of free extents and serves allocate and free
// requests against it, one response per request.
// ----------------------------------------------------------------------------
// The block holds up to MAP_ENTRIES free extents (base and length, ADDR_BITS
// wide each) in one RAM, sorted by base, together with a count of the entries
// in use. An allocate request takes the lowest extent that is long enough,
// returns its base and shrinks it; an extent that runs empty is removed and
// the later entries move down. A free request merges with its neighbors where
// the addresses meet exactly, and otherwise is inserted in address order with
// the later entries moving up; a free that needs a new entry while the table
// is full is dropped with status map_full, and an allocate that finds nothing
// answers base 0 with status no_space. Merged lengths saturate at all ones and
// an advanced base wraps within ADDR_BITS. Requests are served one at a time.
// The scan reads one entry per cycle through the single read port of the
// table RAM, and every entry that moves on a remove or an insert is read once
// and written once. After reset the table is empty at once; the RAM needs no
// clearing pass because entries past the count are never read. A finished
// response waits in an output register, and the next request is accepted
// while it waits there.
`default_nettype none

module first_fit_extent_allocator #(
  parameter int MAP_ENTRIES = 64,
  parameter int ADDR_BITS   = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ffea_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output ffea_pkg::rsp_t rsp_o
);

  localparam int IW = $clog2(MAP_ENTRIES);

  // Table RAM port. Each word holds {base, length}.
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [2*ADDR_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [IW-1:0]          mem_raddr;
  logic [2*ADDR_BITS-1:0] mem_rdata;

  // Response handoff from the sequencer to the output register.
  logic           eng_rsp_valid;
  logic           eng_rsp_ready;
  ffea_pkg::rsp_t eng_rsp;

  logic           rsp_valid_q;
  ffea_pkg::rsp_t rsp_q;

  ffea_engine #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (eng_rsp_valid),
    .rsp_ready_i (eng_rsp_ready),
    .rsp_o       (eng_rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ffea_ram #(
    .Width (2 * ADDR_BITS),
    .Depth (MAP_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new response when it is empty or when its
  // current response leaves in the same cycle.
  assign eng_rsp_ready = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else if (eng_rsp_valid && eng_rsp_ready) begin
      rsp_valid_q <= 1'b1;
      rsp_q       <= eng_rsp;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== test/tb_first_fit_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_extent_allocator: self-checking bench for the extent allocator
// A short table of directed requests, then bursts of random requests: scattered
// frees that fill the map, allocates, frees of earlier grants, and raw noise.
// Each response is checked against a typed value or a predictor of the map.
// ----------------------------------------------------------------------------

module tb_first_fit_extent_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ffea_pkg::*;

  localparam int MAP          = 64;
  localparam int AW           = FIELD_BITS;
  localparam int RANDOM_ITEMS = 700;
  // The slowest request scans and shifts the whole map.
  localparam int SETTLE_CYCLES = 2 * MAP + 40;
  localparam int STALL_LIMIT   = 2000;

  typedef logic [AW-1:0] addr_t;

  // One line of the directed table. When has_want is set, the response is
  // typed in by hand; otherwise the predictor supplies it.
  typedef struct {
    req_t  req;
    bit    has_want;
    rsp_t  want;
  } plan_row_t;

  // An extent handed out by an allocate, kept so that it can be freed later.
  typedef struct {
    addr_t base;
    addr_t count;
  } grant_t;

  logic clk;
  logic rst_n;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Predictor copy of the free-extent map. Slots past the used part stay zero.
  addr_t extent_start [MAP];
  addr_t extent_size  [MAP];

  rsp_t      expected_rsps [$];
  grant_t    held_grants   [$];
  plan_row_t directed_rows [$];

  int  mismatches;
  int  requests_sent;
  int  quiet_cycles;
  // While set, neither side inserts gaps, so requests run back to back.
  bit  no_idle;

  first_fit_extent_allocator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor of the extent map.
  // --------------------------------------------------------------------------

  // The used part of the map ends at the first zero length.
  function automatic int extents_in_use();
    int n = 0;
    while (n < MAP && extent_size[n] != '0) n++;
    return n;
  endfunction

  // Merged lengths clip at all ones instead of wrapping.
  function automatic addr_t clipped_sum(addr_t x, addr_t y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[AW] ? '1 : s[AW-1:0];
  endfunction

  // Removes entry pos and moves the rest of the used part down by one.
  function automatic void close_gap(int pos, int n);
    for (int i = pos; i + 1 < n; i++) begin
      extent_start[i] = extent_start[i+1];
      extent_size[i]  = extent_size[i+1];
    end
    if (n > 0) begin
      extent_start[n-1] = '0;
      extent_size[n-1]  = '0;
    end
  endfunction

  // Applies one request to the map and returns the response it must produce.
  function automatic rsp_t serve_request(req_t r);
    rsp_t        res;
    int          n;
    int          p;
    bit          done;
    logic [AW:0] free_end;
    res.granted_base = '0;
    res.status       = STATUS_OK;
    n    = extents_in_use();
    done = 1'b0;
    if (r.operation == OP_ALLOC) begin
      // First fit: the lowest entry that is long enough.
      res.status = STATUS_NO_SPACE;
      for (int i = 0; i < n; i++) begin
        if (!done && extent_size[i] >= r.unit_count) begin
          done             = 1'b1;
          res.granted_base = extent_start[i];
          res.status       = STATUS_OK;
          extent_start[i]  = extent_start[i] + r.unit_count;
          extent_size[i]   = extent_size[i] - r.unit_count;
          if (extent_size[i] == '0) close_gap(i, n);
        end
      end
    end else begin
      // p is the first entry whose base lies above the freed address.
      p = 0;
      while (p < n && extent_start[p] <= r.base_address) p++;
      free_end = {1'b0, r.base_address} + {1'b0, r.unit_count};
      if (p > 0 && ({1'b0, extent_start[p-1]} + {1'b0, extent_size[p-1]}) ==
          {1'b0, r.base_address}) begin
        // Joins the extent below, and possibly the one above as well.
        extent_size[p-1] = clipped_sum(extent_size[p-1], r.unit_count);
        if (p < n && free_end == {1'b0, extent_start[p]}) begin
          extent_size[p-1] = clipped_sum(extent_size[p-1], extent_size[p]);
          close_gap(p, n);
        end
      end else if (p < n && free_end == {1'b0, extent_start[p]}) begin
        extent_start[p] = r.base_address;
        extent_size[p]  = clipped_sum(extent_size[p], r.unit_count);
      end else if (r.unit_count == '0) begin
        // A zero-length free with no neighbor to touch leaves the map alone.
      end else if (n >= MAP) begin
        res.status = STATUS_MAP_FULL;
      end else begin
        for (int i = n; i > p; i--) begin
          extent_start[i] = extent_start[i-1];
          extent_size[i]  = extent_size[i-1];
        end
        extent_start[p] = r.base_address;
        extent_size[p]  = r.unit_count;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic plan_row_t plan_row(op_e op, int count, int addr, bit has_want,
                                         int want_base, status_e want_status);
    plan_row_t row;
    row.req.operation      = op;
    row.req.unit_count     = addr_t'(count);
    row.req.base_address   = addr_t'(addr);
    row.has_want           = has_want;
    row.want.granted_base  = addr_t'(want_base);
    row.want.status        = want_status;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // The expectation is queued before the request is offered, which keeps the
  // store in request order, and valid only drops when a gap is drawn.
  task automatic send_request(input req_t r, input bit has_want, input rsp_t want);
    rsp_t predicted;
    int   gap;
    predicted = serve_request(r);
    if (r.operation == OP_ALLOC && predicted.status == STATUS_OK && r.unit_count != '0)
      held_grants.push_back('{base: predicted.granted_base, count: r.unit_count});
    expected_rsps.push_back(has_want ? want : predicted);
    gap = draw_gap();
    if (gap != 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input req_t r);
    rsp_t unused;
    unused = '0;
    send_request(r, 1'b0, unused);
  endtask

  // Frees at evenly spaced addresses with lengths short of the spacing, so
  // that no two of them touch. Long runs of these drive the map to full.
  task automatic scatter_frees();
    addr_t origin;
    int    stride;
    int    count;
    int    order;
    int    k;
    req_t  r;
    origin = addr_t'($urandom);
    stride = $urandom_range(2, 64);
    count  = $urandom_range(20, 72);
    order  = $urandom_range(0, 2);
    for (int i = 0; i < count; i++) begin
      case (order)
        0: begin
          k = i;
        end
        1: begin
          k = count - 1 - i;
        end
        default: begin
          k = $urandom_range(0, count - 1);
        end
      endcase
      r.operation    = OP_FREE;
      r.base_address = origin + addr_t'(k * stride);
      r.unit_count   = addr_t'($urandom_range(1, stride - 1));
      send_random(r);
    end
  endtask

  task automatic allocate_burst();
    int   count;
    req_t r;
    count = $urandom_range(10, 40);
    for (int i = 0; i < count; i++) begin
      r.operation    = OP_ALLOC;
      r.base_address = addr_t'($urandom);
      if ($urandom_range(0, 7) == 0) r.unit_count = addr_t'($urandom);
      else                           r.unit_count = addr_t'($urandom_range(0, 64));
      send_random(r);
    end
  endtask

  // Hands back earlier grants in random order, which exercises every kind of
  // merge with the extents around them.
  task automatic return_grants();
    int   count;
    int   k;
    req_t r;
    count = $urandom_range(5, 40);
    for (int i = 0; i < count && held_grants.size() != 0; i++) begin
      k              = $urandom_range(0, held_grants.size() - 1);
      r.operation    = OP_FREE;
      r.base_address = held_grants[k].base;
      r.unit_count   = held_grants[k].count;
      held_grants.delete(k);
      send_random(r);
    end
  endtask

  task automatic noise_burst();
    int   count;
    req_t r;
    count = $urandom_range(5, 15);
    for (int i = 0; i < count; i++) begin
      r.operation    = op_e'($urandom_range(0, 1));
      r.unit_count   = addr_t'($urandom);
      r.base_address = addr_t'($urandom);
      send_random(r);
    end
  endtask

  initial begin
    int directed_total;
    clk        = 1'b0;
    rst_n      = 1'b0;
    req_valid  = 1'b0;
    req        = '0;
    no_idle    = 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    for (int i = 0; i < MAP; i++) begin
      extent_start[i] = '0;
      extent_size[i]  = '0;
    end

    // The directed table. Rows with a typed response cover the empty map,
    // the simple grants and the no_space code; the rest go to the predictor.
    directed_rows.push_back(plan_row(OP_ALLOC, 5, 0, 1, 0, STATUS_NO_SPACE));
    directed_rows.push_back(plan_row(OP_ALLOC, 0, 0, 1, 0, STATUS_NO_SPACE));
    directed_rows.push_back(plan_row(OP_FREE, 0, 'h100, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_FREE, 'h100, 'h100, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 0, 0, 1, 'h100, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 'h10, 0, 1, 'h100, STATUS_OK));
    // Joins the extent above it.
    directed_rows.push_back(plan_row(OP_FREE, 'h10, 'h100, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_FREE, 'h40, 'h400, 1, 0, STATUS_OK));
    // Fills the hole exactly, joining both neighbors into one entry.
    directed_rows.push_back(plan_row(OP_FREE, 'h200, 'h200, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 'hFFFFFF, 0, 1, 0, STATUS_NO_SPACE));
    // Zero length right at the end of an extent.
    directed_rows.push_back(plan_row(OP_FREE, 0, 'h440, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_FREE, 'h10, 0, 1, 0, STATUS_OK));
    // Top of the address range; its end is compared without wrapping.
    directed_rows.push_back(plan_row(OP_FREE, 'hFFFFFF, 'hFFFFFF, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 'h20, 0, 0, 0, STATUS_OK));
    // Joins both neighbors, and the merged length clips at all ones.
    directed_rows.push_back(plan_row(OP_FREE, 'hFFFBBF, 'h440, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 'hFFFFFF, 0, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_FREE, 'h20, 'hFFFFF0, 1, 0, STATUS_OK));
    // Advances that base past the top, so it wraps to a low address.
    directed_rows.push_back(plan_row(OP_ALLOC, 'h18, 0, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 8, 0, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 8, 0, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 8, 0, 0, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 1, 'hFFFFFF, 1, 0, STATUS_NO_SPACE));
    directed_rows.push_back(plan_row(OP_FREE, 1, 'h555555, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_FREE, 'hAAAAAA, 'hAAAAAA, 1, 0, STATUS_OK));
    directed_rows.push_back(plan_row(OP_ALLOC, 'h555555, 'h555555, 0, 0, STATUS_OK));
    directed_total = directed_rows.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);

    // Random bursts. Every burst picks whether both sides run without gaps.
    while (requests_sent < directed_total + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          scatter_frees();
        end
        3, 4, 5: begin
          allocate_burst();
        end
        6, 7, 8: begin
          return_grants();
        end
        default: begin
          noise_burst();
        end
      endcase
    end
    req_valid = 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    // Any response beyond the last expected one would show up in this window.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: ready stalls for a random number of cycles, then stays
  // high until one response is taken.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap();
      if (stall != 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Each response taken is matched against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: response with none expected: expected none, actual base %h status %0d",
                 $time, rsp.granted_base, rsp.status);
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.granted_base !== want.granted_base) begin
          $display("%0t: granted_base expected %h actual %h",
                   $time, want.granted_base, rsp.granted_base);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too many cycles without a request or a response taken means
  // the block has hung.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
